### hw/rtl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared types, codes and helpers of the grid maze backtracker.
// ----------------------------------------------------------------------------
package gmb_pkg;

    localparam int CFG_W        = 6;
    localparam int DEFAULT_SIZE = 20;
    localparam int MODE_W       = 2;
    localparam int RND_W        = 31;
    localparam int ADDR_W       = 10;
    localparam int WALL_W       = 4;
    localparam int DIR_W        = 2;
    localparam int CELL_W       = 5;    // visited bit over four wall bits

    // Input modes
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Move directions
    localparam logic [DIR_W-1:0] DIR_N    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_S    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_E    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_WEST = 2'd3;

    // Wall bits
    localparam logic [WALL_W-1:0] WALL_N    = 4'b0001;
    localparam logic [WALL_W-1:0] WALL_S    = 4'b0010;
    localparam logic [WALL_W-1:0] WALL_E    = 4'b0100;
    localparam logic [WALL_W-1:0] WALL_WEST = 4'b1000;
    localparam logic [WALL_W-1:0] ALL_WALLS = 4'b1111;

    typedef enum logic [4:0] {
        ST_RST_CLR,
        ST_IDLE,
        ST_CLR,
        ST_START_WR,
        ST_STEP,
        ST_TOP_RD,
        ST_TOP_LD,
        ST_RD_N,
        ST_RD_S,
        ST_RD_E,
        ST_RD_W,
        ST_RD_CUR,
        ST_DECIDE,
        ST_CARVE,
        ST_FIN_RD1,
        ST_FIN_WR1,
        ST_FIN_RD2,
        ST_FIN_WR2,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RS_N,
        RS_S,
        RS_E,
        RS_W,
        RS_CUR,
        RS_BOT,
        RS_MID,
        RS_ADDR
    } rsel_t;

    typedef struct packed {
        logic             latch_in;
        logic             start_init;
        logic             clr_wr;
        logic             start_wr;
        logic             stk_rd;
        logic             top_ld;
        logic             mem_rd;
        rsel_t            rd_sel;
        logic             cap_en;
        logic [DIR_W-1:0] cap_dir;
        logic             pop;
        logic             carve_cur;
        logic             carve_nx;
        logic             fin_wr_s;
        logic             fin_wr_n;
        logic             res_read;
        logic             res_fin;
        logic             emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic addr_ok;
        logic clr_last;
        logic clr_last_all;
        logic has_free;
        logic depth_one;
        logic out_free;
    } status_t;

    function automatic logic [WALL_W-1:0] own_wall(input logic [DIR_W-1:0] d);
        logic [WALL_W-1:0] w;
        case (d)
            DIR_N:   w = WALL_N;
            DIR_S:   w = WALL_S;
            DIR_E:   w = WALL_E;
            default: w = WALL_WEST;
        endcase
        return w;
    endfunction

    function automatic logic [WALL_W-1:0] far_wall(input logic [DIR_W-1:0] d);
        logic [WALL_W-1:0] w;
        case (d)
            DIR_N:   w = WALL_S;
            DIR_S:   w = WALL_N;
            DIR_E:   w = WALL_WEST;
            default: w = WALL_E;
        endcase
        return w;
    endfunction

    // Remainder by three: base-4 digits sum to the same residue.
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [31:0] x;
        logic [5:0]  s;
        logic [3:0]  t;
        logic [2:0]  u;
        x = {1'b0, v};
        s = '0;
        for (int i = 0; i < 16; i++)
        begin
            s = s + 6'(x[2*i +: 2]);
        end
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        u = 3'(t[1:0]) + 3'(t[3:2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // Used range of a dimension register: zero reads as one, saturate at max.
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int max_v);
        int r;
        r = int'(v);
        if (r < 1)
        begin
            r = 1;
        end
        if (r > max_v)
        begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

### hw/rtl/gmb_ifs.sv
// ----------------------------------------------------------------------------
// gmb_ifs
// Valid/ready channels for the maze backtracker: request items and results.
// ----------------------------------------------------------------------------
interface gmb_in_if;
    logic                            valid;
    logic                            ready;
    logic [gmb_pkg::MODE_W-1:0]      mode;
    logic [gmb_pkg::RND_W-1:0]       random_value;
    logic [gmb_pkg::ADDR_W-1:0]      cell_address;

    modport source (output valid, output mode, output random_value,
                    output cell_address, input ready);
    modport sink   (input valid, input mode, input random_value,
                    input cell_address, output ready);
endinterface

interface gmb_out_if;
    logic                            valid;
    logic                            ready;
    logic [gmb_pkg::ADDR_W-1:0]      cell_index;
    logic [gmb_pkg::WALL_W-1:0]      walls;
    logic                            visited;
    logic                            carved;
    logic [gmb_pkg::DIR_W-1:0]       direction;
    logic                            finished;

    modport source (output valid, output cell_index, output walls, output visited,
                    output carved, output direction, output finished, input ready);
    modport sink   (input valid, input cell_index, input walls, input visited,
                    input carved, input direction, input finished, output ready);
endinterface

### hw/rtl/grid_maze_backtracker.sv
// ----------------------------------------------------------------------------
// grid_maze_backtracker
// Randomized depth-first maze builder on a grid, with an explicit walk stack.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  in_ch     in    valid/ready        mode, random_value, cell_address
//  out_ch    out   valid/ready        cell_index, walls, visited, carved,
//                                     direction, finished
//  cfg       in    cfg_we (no stall)  cfg_index, cfg_data
//
//  A read item outside the grid skips the cell store read; a step on a
//  finished maze only reports the finished mark. A step pops stack cells
//  until the top cell has a free neighbor and carves to it, or ends the
//  walk once the last stack cell is popped.
//  Every pass reads five cells through the single cell store read port.
//  Start: clears width*height cells, one cell cleared per cycle.
//  After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells runs
//  before the first item is accepted.
//  Items are taken one at a time; a finished result waits in the output
//  register while the next item is accepted and worked on.
//
module grid_maze_backtracker #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    gmb_in_if.sink                    in_ch,
    gmb_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0] cfg_data
);

    gmb_pkg::cmd_t    cmd;
    gmb_pkg::status_t status;
    logic             in_ready;

    // Sequencer: walks each item through its memory accesses
    gmb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Cell store, stack, neighbor choice and output register
    gmb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_random_value (in_ch.random_value),
        .in_cell_address (in_ch.cell_address),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_cell_index  (out_ch.cell_index),
        .out_walls       (out_ch.walls),
        .out_visited     (out_ch.visited),
        .out_carved      (out_ch.carved),
        .out_direction   (out_ch.direction),
        .out_finished    (out_ch.finished)
    );

endmodule

### hw/rtl/gmb_ctrl.sv
// ----------------------------------------------------------------------------
// gmb_ctrl
// Sequencer of the maze backtracker: issues datapath commands per state.
// ----------------------------------------------------------------------------
module gmb_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [gmb_pkg::MODE_W-1:0] in_mode,
    input  gmb_pkg::status_t           status,
    output logic                       in_ready,
    output gmb_pkg::cmd_t              cmd
);

    gmb_pkg::state_t state_reg;
    gmb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmb_pkg::ST_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            gmb_pkg::ST_RST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last_all)
                begin
                    state_next = gmb_pkg::ST_IDLE;
                end
            end
            gmb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (in_mode)
                        gmb_pkg::MODE_START:
                        begin
                            cmd.start_init = 1'b1;
                            state_next     = gmb_pkg::ST_CLR;
                        end
                        gmb_pkg::MODE_STEP: state_next = gmb_pkg::ST_STEP;
                        gmb_pkg::MODE_READ: state_next = gmb_pkg::ST_RD_ISSUE;
                        default:            state_next = gmb_pkg::ST_IDLE;
                    endcase
                end
            end
            gmb_pkg::ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = gmb_pkg::ST_START_WR;
                end
            end
            gmb_pkg::ST_START_WR:
            begin
                cmd.start_wr = 1'b1;
                state_next   = gmb_pkg::ST_EMIT;
            end
            gmb_pkg::ST_STEP:
            begin
                if (status.done)
                begin
                    cmd.res_fin = 1'b1;
                    state_next  = gmb_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = gmb_pkg::ST_TOP_RD;
                end
            end
            gmb_pkg::ST_TOP_RD:
            begin
                cmd.stk_rd = 1'b1;
                state_next = gmb_pkg::ST_TOP_LD;
            end
            gmb_pkg::ST_TOP_LD:
            begin
                cmd.top_ld = 1'b1;
                state_next = gmb_pkg::ST_RD_N;
            end
            gmb_pkg::ST_RD_N:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = gmb_pkg::RS_N;
                state_next = gmb_pkg::ST_RD_S;
            end
            gmb_pkg::ST_RD_S:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dir = gmb_pkg::DIR_N;
                cmd.mem_rd  = 1'b1;
                cmd.rd_sel  = gmb_pkg::RS_S;
                state_next  = gmb_pkg::ST_RD_E;
            end
            gmb_pkg::ST_RD_E:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dir = gmb_pkg::DIR_S;
                cmd.mem_rd  = 1'b1;
                cmd.rd_sel  = gmb_pkg::RS_E;
                state_next  = gmb_pkg::ST_RD_W;
            end
            gmb_pkg::ST_RD_W:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dir = gmb_pkg::DIR_E;
                cmd.mem_rd  = 1'b1;
                cmd.rd_sel  = gmb_pkg::RS_W;
                state_next  = gmb_pkg::ST_RD_CUR;
            end
            gmb_pkg::ST_RD_CUR:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dir = gmb_pkg::DIR_WEST;
                cmd.mem_rd  = 1'b1;
                cmd.rd_sel  = gmb_pkg::RS_CUR;
                state_next  = gmb_pkg::ST_DECIDE;
            end
            gmb_pkg::ST_DECIDE:
            begin
                if (status.has_free)
                begin
                    cmd.carve_cur = 1'b1;
                    state_next    = gmb_pkg::ST_CARVE;
                end
                else
                begin
                    cmd.pop = 1'b1;
                    if (status.depth_one)
                    begin
                        state_next = gmb_pkg::ST_FIN_RD1;
                    end
                    else
                    begin
                        state_next = gmb_pkg::ST_TOP_RD;
                    end
                end
            end
            gmb_pkg::ST_CARVE:
            begin
                cmd.carve_nx = 1'b1;
                state_next   = gmb_pkg::ST_EMIT;
            end
            gmb_pkg::ST_FIN_RD1:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = gmb_pkg::RS_BOT;
                state_next = gmb_pkg::ST_FIN_WR1;
            end
            gmb_pkg::ST_FIN_WR1:
            begin
                cmd.fin_wr_s = 1'b1;
                state_next   = gmb_pkg::ST_FIN_RD2;
            end
            gmb_pkg::ST_FIN_RD2:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = gmb_pkg::RS_MID;
                state_next = gmb_pkg::ST_FIN_WR2;
            end
            gmb_pkg::ST_FIN_WR2:
            begin
                cmd.fin_wr_n = 1'b1;
                cmd.res_fin  = 1'b1;
                state_next   = gmb_pkg::ST_EMIT;
            end
            gmb_pkg::ST_RD_ISSUE:
            begin
                if (status.addr_ok)
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = gmb_pkg::RS_ADDR;
                    state_next = gmb_pkg::ST_RD_DATA;
                end
                else
                begin
                    cmd.res_read = 1'b1;
                    state_next   = gmb_pkg::ST_EMIT;
                end
            end
            gmb_pkg::ST_RD_DATA:
            begin
                cmd.res_read = 1'b1;
                state_next   = gmb_pkg::ST_EMIT;
            end
            gmb_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gmb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gmb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gmb_datapath.sv
// ----------------------------------------------------------------------------
// gmb_datapath
// Cell store, walk stack, neighbor pick, result and output registers.
// ----------------------------------------------------------------------------
module gmb_datapath #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  gmb_pkg::cmd_t               cmd,
    output gmb_pkg::status_t            status,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0]   cfg_data,
    input  logic [gmb_pkg::RND_W-1:0]   in_random_value,
    input  logic [gmb_pkg::ADDR_W-1:0]  in_cell_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gmb_pkg::ADDR_W-1:0]  out_cell_index,
    output logic [gmb_pkg::WALL_W-1:0]  out_walls,
    output logic                        out_visited,
    output logic                        out_carved,
    output logic [gmb_pkg::DIR_W-1:0]   out_direction,
    output logic                        out_finished
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int SW    = XW + YW;
    localparam int CLW   = gmb_pkg::CELL_W;
    localparam int VIS   = gmb_pkg::WALL_W;     // visited bit position

    // Configuration and active grid
    logic [gmb_pkg::CFG_W-1:0] grid_width_reg;
    logic [gmb_pkg::CFG_W-1:0] grid_height_reg;
    logic [DW-1:0]             act_w_reg;
    logic [HW-1:0]             act_h_reg;
    logic [CW-1:0]             area_reg;
    logic [DW-1:0]             act_w_next;
    logic [HW-1:0]             act_h_next;

    // Walk state
    logic [AW-1:0]             clr_idx_reg;
    logic [CW-1:0]             depth_reg;
    logic                      done_reg;

    // Latched item
    logic [1:0]                rnd2_reg;
    logic [1:0]                rmod3_reg;
    logic [gmb_pkg::ADDR_W-1:0] addr_in_reg;

    // Current top cell and neighbor captures
    logic [XW-1:0]             cx_reg;
    logic [YW-1:0]             cy_reg;
    logic [AW-1:0]             cur_idx_reg;
    logic [CLW-1:0]            nb_val_reg [4];
    logic [gmb_pkg::DIR_W-1:0] sel_dir_reg;
    logic [AW-1:0]             nx_idx_reg;
    logic [CLW-1:0]            nx_val_reg;
    logic [XW-1:0]             nxx_reg;
    logic [YW-1:0]             nxy_reg;

    // Memories
    logic [CLW-1:0]            cell_mem [CELLS];
    logic [SW-1:0]             stack_mem [CELLS];
    logic [CLW-1:0]            rd_data_reg;
    logic [SW-1:0]             stk_data_reg;

    // Pending result and output stage
    logic [gmb_pkg::ADDR_W-1:0] res_idx_reg;
    logic [gmb_pkg::WALL_W-1:0] res_walls_reg;
    logic                       res_vis_reg;
    logic                       res_carved_reg;
    logic [gmb_pkg::DIR_W-1:0]  res_dir_reg;
    logic                       res_fin_reg;
    logic                       out_valid_reg;
    logic [gmb_pkg::ADDR_W-1:0] out_idx_reg;
    logic [gmb_pkg::WALL_W-1:0] out_walls_reg;
    logic                       out_vis_reg;
    logic                       out_carved_reg;
    logic [gmb_pkg::DIR_W-1:0]  out_dir_reg;
    logic                       out_fin_reg;

    // Combinational
    logic [AW-1:0]             nb_addr [4];
    logic [3:0]                inb;
    logic [3:0]                free;
    logic [2:0]                free_cnt;
    logic [1:0]                pick_k;
    logic [gmb_pkg::DIR_W-1:0] pick_dir;
    logic [AW-1:0]             bot_addr;
    logic [AW-1:0]             mid_addr;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [CLW-1:0]            wr_data;
    logic [CLW-1:0]            pick_val;

    assign act_w_next = DW'(gmb_pkg::clamp_dim(grid_width_reg, MAX_WIDTH));
    assign act_h_next = HW'(gmb_pkg::clamp_dim(grid_height_reg, MAX_HEIGHT));

    // Neighbor addresses and in-grid flags of the top cell
    assign nb_addr[0] = cur_idx_reg - AW'(act_w_reg);
    assign nb_addr[1] = cur_idx_reg + AW'(act_w_reg);
    assign nb_addr[2] = cur_idx_reg + AW'(1);
    assign nb_addr[3] = cur_idx_reg - AW'(1);
    assign inb[0] = (cy_reg != '0);
    assign inb[1] = ((HW'(cy_reg) + HW'(1)) < act_h_reg);
    assign inb[2] = ((DW'(cx_reg) + DW'(1)) < act_w_reg);
    assign inb[3] = (cx_reg != '0);

    always_comb
    begin
        logic [1:0] seen;
        logic       found;
        seen     = '0;
        found    = 1'b0;
        pick_dir = gmb_pkg::DIR_N;
        free_cnt = '0;
        for (int d = 0; d < 4; d++)
        begin
            free[d]  = inb[d] & ~nb_val_reg[d][VIS];
            free_cnt = free_cnt + 3'(free[d]);
        end
        case (free_cnt)
            3'd2:    pick_k = {1'b0, rnd2_reg[0]};
            3'd3:    pick_k = rmod3_reg;
            3'd4:    pick_k = rnd2_reg;
            default: pick_k = '0;
        endcase
        for (int d = 0; d < 4; d++)
        begin
            if (free[d])
            begin
                if (!found && (seen == pick_k))
                begin
                    pick_dir = 2'(d);
                    found    = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
    end

    assign pick_val = nb_val_reg[pick_dir];
    assign mid_addr = AW'(act_w_reg >> 1);
    assign bot_addr = AW'(area_reg - CW'(act_w_reg) + CW'(act_w_reg >> 1));

    always_comb
    begin
        case (cmd.rd_sel)
            gmb_pkg::RS_N:   rd_addr = nb_addr[0];
            gmb_pkg::RS_S:   rd_addr = nb_addr[1];
            gmb_pkg::RS_E:   rd_addr = nb_addr[2];
            gmb_pkg::RS_W:   rd_addr = nb_addr[3];
            gmb_pkg::RS_CUR: rd_addr = cur_idx_reg;
            gmb_pkg::RS_BOT: rd_addr = bot_addr;
            gmb_pkg::RS_MID: rd_addr = mid_addr;
            default:         rd_addr = AW'(addr_in_reg);
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b0, gmb_pkg::ALL_WALLS};
        if (cmd.clr_wr)
        begin
            wr_addr = clr_idx_reg;
        end
        else if (cmd.start_wr)
        begin
            wr_data = {1'b1, gmb_pkg::ALL_WALLS};
        end
        else if (cmd.carve_cur)
        begin
            wr_addr = cur_idx_reg;
            wr_data = rd_data_reg & ~{1'b0, gmb_pkg::own_wall(pick_dir)};
        end
        else if (cmd.carve_nx)
        begin
            wr_addr = nx_idx_reg;
            wr_data = nx_val_reg;
        end
        else if (cmd.fin_wr_s)
        begin
            wr_addr = bot_addr;
            wr_data = rd_data_reg & ~{1'b0, gmb_pkg::WALL_S};
        end
        else if (cmd.fin_wr_n)
        begin
            wr_addr = mid_addr;
            wr_data = rd_data_reg & ~{1'b0, gmb_pkg::WALL_N};
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    // Cell store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    // Walk stack
    always_ff @(posedge clk)
    begin
        if (cmd.start_wr)
        begin
            stack_mem[0] <= '0;
        end
        else if (cmd.carve_nx && (depth_reg < CW'(CELLS)))
        begin
            stack_mem[depth_reg[AW-1:0]] <= {nxy_reg, nxx_reg};
        end
        if (cmd.stk_rd)
        begin
            stk_data_reg <= stack_mem[AW'(depth_reg - CW'(1))];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE);
            grid_height_reg <= gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE);
            act_w_reg       <= DW'(gmb_pkg::clamp_dim(
                                   gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE), MAX_WIDTH));
            act_h_reg       <= HW'(gmb_pkg::clamp_dim(
                                   gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE), MAX_HEIGHT));
            area_reg        <= CW'(gmb_pkg::clamp_dim(
                                   gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE), MAX_WIDTH)
                                 * gmb_pkg::clamp_dim(
                                   gmb_pkg::CFG_W'(gmb_pkg::DEFAULT_SIZE), MAX_HEIGHT));
            clr_idx_reg     <= '0;
            depth_reg       <= '0;
            done_reg        <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == gmb_pkg::REG_GRID_WIDTH)
                begin
                    grid_width_reg <= cfg_data;
                end
                else
                begin
                    grid_height_reg <= cfg_data;
                end
            end
            if (cmd.start_init)
            begin
                act_w_reg   <= act_w_next;
                act_h_reg   <= act_h_next;
                area_reg    <= CW'(act_w_next) * CW'(act_h_next);
                clr_idx_reg <= '0;
            end
            else if (cmd.clr_wr)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.start_wr)
            begin
                depth_reg <= CW'(1);
                done_reg  <= 1'b0;
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_reg - CW'(1);
            end
            else if (cmd.carve_nx && (depth_reg < CW'(CELLS)))
            begin
                depth_reg <= depth_reg + CW'(1);
            end
            if (cmd.fin_wr_n)
            begin
                done_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            rnd2_reg    <= in_random_value[1:0];
            rmod3_reg   <= gmb_pkg::mod3(in_random_value);
            addr_in_reg <= in_cell_address;
        end
        if (cmd.top_ld)
        begin
            cx_reg      <= stk_data_reg[XW-1:0];
            cy_reg      <= stk_data_reg[SW-1:XW];
            cur_idx_reg <= AW'(stk_data_reg[SW-1:XW]) * AW'(act_w_reg)
                         + AW'(stk_data_reg[XW-1:0]);
        end
        if (cmd.cap_en)
        begin
            nb_val_reg[cmd.cap_dir] <= rd_data_reg;
        end
        if (cmd.carve_cur)
        begin
            sel_dir_reg <= pick_dir;
            nx_idx_reg  <= nb_addr[pick_dir];
            nx_val_reg  <= (pick_val & ~{1'b0, gmb_pkg::far_wall(pick_dir)})
                         | {1'b1, {gmb_pkg::WALL_W{1'b0}}};
            nxx_reg     <= cx_reg;
            nxy_reg     <= cy_reg;
            case (pick_dir)
                gmb_pkg::DIR_N: nxy_reg <= cy_reg - YW'(1);
                gmb_pkg::DIR_S: nxy_reg <= cy_reg + YW'(1);
                gmb_pkg::DIR_E: nxx_reg <= cx_reg + XW'(1);
                default:        nxx_reg <= cx_reg - XW'(1);
            endcase
        end
        if (cmd.start_wr)
        begin
            res_idx_reg    <= '0;
            res_walls_reg  <= gmb_pkg::ALL_WALLS;
            res_vis_reg    <= 1'b1;
            res_carved_reg <= 1'b0;
            res_dir_reg    <= '0;
            res_fin_reg    <= 1'b0;
        end
        else if (cmd.carve_nx)
        begin
            res_idx_reg    <= gmb_pkg::ADDR_W'(nx_idx_reg);
            res_walls_reg  <= nx_val_reg[gmb_pkg::WALL_W-1:0];
            res_vis_reg    <= 1'b1;
            res_carved_reg <= 1'b1;
            res_dir_reg    <= sel_dir_reg;
            res_fin_reg    <= 1'b0;
        end
        else if (cmd.res_fin)
        begin
            res_idx_reg    <= '0;
            res_walls_reg  <= '0;
            res_vis_reg    <= 1'b0;
            res_carved_reg <= 1'b0;
            res_dir_reg    <= '0;
            res_fin_reg    <= 1'b1;
        end
        else if (cmd.res_read)
        begin
            res_idx_reg    <= addr_in_reg;
            res_walls_reg  <= status.addr_ok ? rd_data_reg[gmb_pkg::WALL_W-1:0] : '0;
            res_vis_reg    <= status.addr_ok & rd_data_reg[VIS];
            res_carved_reg <= 1'b0;
            res_dir_reg    <= '0;
            res_fin_reg    <= done_reg;
        end
        if (cmd.emit)
        begin
            out_idx_reg    <= res_idx_reg;
            out_walls_reg  <= res_walls_reg;
            out_vis_reg    <= res_vis_reg;
            out_carved_reg <= res_carved_reg;
            out_dir_reg    <= res_dir_reg;
            out_fin_reg    <= res_fin_reg;
        end
    end

    assign status.done         = done_reg;
    assign status.addr_ok      = (32'(addr_in_reg) < 32'(area_reg));
    assign status.clr_last     = (clr_idx_reg == AW'(area_reg - CW'(1)));
    assign status.clr_last_all = (clr_idx_reg == AW'(CELLS - 1));
    assign status.has_free     = |free;
    assign status.depth_one    = (depth_reg == CW'(1));
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_cell_index = out_idx_reg;
    assign out_walls      = out_walls_reg;
    assign out_visited    = out_vis_reg;
    assign out_carved     = out_carved_reg;
    assign out_direction  = out_dir_reg;
    assign out_finished   = out_fin_reg;

    // A result never overwrites one still waiting at the output
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending output");

    // A carve only happens with at least one free neighbor
    a_carve_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.carve_cur |-> (free != 4'b0000))
        else $error("carve without a free neighbor");

    // Pops never underflow the stack
    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (depth_reg != '0))
        else $error("stack pop while empty");

    // Starting a maze leaves one entry and clears the finished mark
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_wr |=> (!done_reg && (depth_reg == CW'(1))))
        else $error("start did not set up the walk");

endmodule
